// ===== sv/sfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

	localparam int          STORE_DEPTH   = 20;
	localparam logic [7:0]  FRAME_LEN     = 8'd23;
	localparam logic [7:0]  CRC_SPAN      = 8'd21;
	localparam logic [7:0]  CHECK_HI_IDX  = 8'd21;
	localparam logic [7:0]  CHECK_LO_IDX  = 8'd22;
	localparam logic [7:0]  COUNT_MAX     = 8'd255;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [7:0]  MARKER_RESET  = 8'hAA;

	localparam logic [1:0]  ST_OK         = 2'd0;
	localparam logic [1:0]  ST_BAD_LEN    = 2'd1;
	localparam logic [1:0]  ST_BAD_START  = 2'd2;
	localparam logic [1:0]  ST_BAD_CRC    = 2'd3;

	// first member sits in the top bits, so node_number lands at bit 0
	typedef struct packed {
		logic [15:0]        node_state_alert;
		logic signed [15:0] tilt_angle;
		logic [15:0]        vibration_level;
		logic signed [15:0] rate_z;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_x;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
		logic [7:0]         sequence_number;
		logic [7:0]         node_number;
	} fields_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		fields_t    fields;
	} frame_res_t;

	// CRC-16, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sensor_frame_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast end_of_packet
// m_*       out  m_tvalid/m_tready  m_tdata (decoded fields), m_tuser frame_status
// cfg_*     in   cfg_we             cfg_wdata start_marker
//
// One word per cycle while s_tready is high; the result of a frame is registered
// and appears in the cycle after its last word. The output register sets the rate:
// input stalls only while a result waits and m_tready is low.
// Reset clears the packet state, the pending result and sets start_marker to 0xAA.
// The per-byte CRC update is one byte-wide XOR network ahead of the state registers.

module sensor_frame_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] data_byte
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [7:0] node_number, [15:8] sequence_number, [31:16] accel_x, [47:32] accel_y,
	// [63:48] accel_z, [79:64] rate_x, [95:80] rate_y, [111:96] rate_z,
	// [127:112] vibration_level, [143:128] tilt_angle, [159:144] node_state_alert
	output logic [159:0]      m_tdata,
	output logic [1:0]        m_tuser,  // [1:0] frame_status
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_wdata
);

	logic [7:0]          start_marker_q;
	logic                can_load;
	logic                accept;
	sfc_pkg::frame_res_t res;

	assign s_tready = can_load;
	assign accept   = s_tvalid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= sfc_pkg::MARKER_RESET;
		end else if (cfg_we) begin
			start_marker_q <= cfg_wdata;
		end
	end

	sfc_frame_acc u_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.end_of_packet (s_tlast),
		.start_marker  (start_marker_q),
		.res           (res)
	);

	sfc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.can_load (can_load),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	a_marker_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> start_marker_q == $past(cfg_wdata))
		else $error("start marker write lost");

	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> s_tready && s_tlast)
		else $error("result raised without an accepted last word");
`endif

endmodule

`default_nettype wire

// ===== sv/sfc_frame_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfc_frame_acc (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_packet,
	input  wire logic [7:0]        start_marker,
	output sfc_pkg::frame_res_t    res
);

	logic [7:0]  byte_count_q;
	logic [15:0] crc_q;
	logic        start_ok_q;
	logic [15:0] check_q;
	logic [7:0]  store_q [sfc_pkg::STORE_DEPTH];

	logic [7:0]  count_n;
	logic [15:0] crc_n;
	logic        start_ok_n;
	logic [15:0] check_n;
	logic [1:0]  status;
	sfc_pkg::fields_t fields;

	always_comb begin
		count_n = (byte_count_q == sfc_pkg::COUNT_MAX) ? byte_count_q : byte_count_q + 8'd1;
		start_ok_n = (byte_count_q == 8'd0) ? (data_byte == start_marker) : start_ok_q;
		crc_n = (byte_count_q < sfc_pkg::CRC_SPAN) ? sfc_pkg::crc16_byte(crc_q, data_byte)
			: crc_q;
		check_n = check_q;
		if (byte_count_q == sfc_pkg::CHECK_HI_IDX) begin
			check_n = {data_byte, check_q[7:0]};
		end else if (byte_count_q == sfc_pkg::CHECK_LO_IDX) begin
			check_n = {check_q[15:8], data_byte};
		end
	end

	// a full-length frame ends on byte 22, so the CRC and start flag are already final
	always_comb begin
		if (count_n != sfc_pkg::FRAME_LEN) begin
			status = sfc_pkg::ST_BAD_LEN;
		end else if (!start_ok_q) begin
			status = sfc_pkg::ST_BAD_START;
		end else if (crc_q != check_n) begin
			status = sfc_pkg::ST_BAD_CRC;
		end else begin
			status = sfc_pkg::ST_OK;
		end
	end

	always_comb begin
		fields = '0;
		if (status == sfc_pkg::ST_OK) begin
			fields.node_number      = store_q[0];
			fields.sequence_number  = store_q[1];
			fields.accel_x          = {store_q[2], store_q[3]};
			fields.accel_y          = {store_q[4], store_q[5]};
			fields.accel_z          = {store_q[6], store_q[7]};
			fields.rate_x           = {store_q[8], store_q[9]};
			fields.rate_y           = {store_q[10], store_q[11]};
			fields.rate_z           = {store_q[12], store_q[13]};
			fields.vibration_level  = {store_q[14], store_q[15]};
			fields.tilt_angle       = {store_q[16], store_q[17]};
			fields.node_state_alert = {store_q[18], store_q[19]};
		end
	end

	assign res.valid  = accept && end_of_packet;
	assign res.status = status;
	assign res.fields = fields;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 8'd0;
			crc_q        <= sfc_pkg::CRC_INIT;
			start_ok_q   <= 1'b1;
			check_q      <= 16'd0;
		end else if (accept) begin
			if (end_of_packet) begin
				byte_count_q <= 8'd0;
				crc_q        <= sfc_pkg::CRC_INIT;
				start_ok_q   <= 1'b1;
				check_q      <= 16'd0;
			end else begin
				byte_count_q <= count_n;
				crc_q        <= crc_n;
				start_ok_q   <= start_ok_n;
				check_q      <= check_n;
			end
		end
	end

	// bytes 1..20 of the frame
	always_ff @(posedge clk) begin
		for (int i = 0; i < sfc_pkg::STORE_DEPTH; i++) begin
			if (accept && byte_count_q == 8'(i + 1)) begin
				store_q[i] <= data_byte;
			end
		end
	end

`ifndef SYNTH
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_packet |=> byte_count_q == 8'd0 && crc_q == sfc_pkg::CRC_INIT)
		else $error("packet state not cleared after last word");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_of_packet && byte_count_q != sfc_pkg::COUNT_MAX
		|=> byte_count_q == 8'($past(byte_count_q) + 8'd1))
		else $error("byte count did not advance");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && status != sfc_pkg::ST_OK |-> fields == '0)
		else $error("decoded fields not zero on failed frame");
`endif

endmodule

`default_nettype wire

// ===== sv/sfc_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfc_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfc_pkg::frame_res_t res,
	output logic                   can_load,
	input  wire logic              m_tready,
	output logic                   m_tvalid,
	output logic [159:0]           m_tdata,
	output logic [1:0]             m_tuser
);

	logic             valid_q;
	logic [1:0]       status_q;
	sfc_pkg::fields_t fields_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && res.valid) begin
			status_q <= res.status;
			fields_q <= res.fields;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = fields_q;
	assign m_tuser  = status_q;

`ifndef SYNTH
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		can_load && res.valid |=> m_tvalid && m_tuser == $past(res.status))
		else $error("result word not presented after load");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		!can_load |=> m_tvalid && $stable(m_tuser))
		else $error("pending result word changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== bench/sfc_frame_monitor.sv =====
`timescale 1ns / 1ps

module sfc_frame_monitor
	import sfc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [159:0] m_tdata,   // decoded fields, node_number at bit 0
	input  wire logic [1:0]   m_tuser,   // [1:0] frame_status
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_wdata,
	output int unsigned       pending,
	output int unsigned       failures
);

	typedef struct {
		logic [1:0] status;
		fields_t    fields;
	} frame_verdict_t;

	frame_verdict_t verdict_q[$];
	frame_verdict_t want;
	fields_t        seen;

	logic [7:0]  marker;
	logic [7:0]  byte_cnt;
	logic [15:0] crc_acc;
	logic        start_hit;
	logic [7:0]  payload [STORE_DEPTH];
	logic [15:0] rx_check;
	int unsigned fail_cnt;

	function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	function automatic logic [15:0] be_word(input int first);
		return {payload[first], payload[first + 1]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q.delete();
			marker = MARKER_RESET;
			byte_cnt = '0;
			crc_acc = CRC_INIT;
			start_hit = 1'b1;
			rx_check = '0;
			for (int i = 0; i < STORE_DEPTH; i++) payload[i] = '0;
			fail_cnt = 0;
		end else begin
			// compare first: a frame closed at this edge cannot be on the output yet
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$error("result word with no frame pending: frame_status %0d", m_tuser);
					fail_cnt++;
				end else begin
					want = verdict_q.pop_front();
					seen = m_tdata;
					check_field("frame_status", 16'(want.status), 16'(m_tuser));
					check_field("node_number", 16'(want.fields.node_number),
						16'(seen.node_number));
					check_field("sequence_number", 16'(want.fields.sequence_number),
						16'(seen.sequence_number));
					check_field("accel_x", want.fields.accel_x, seen.accel_x);
					check_field("accel_y", want.fields.accel_y, seen.accel_y);
					check_field("accel_z", want.fields.accel_z, seen.accel_z);
					check_field("rate_x", want.fields.rate_x, seen.rate_x);
					check_field("rate_y", want.fields.rate_y, seen.rate_y);
					check_field("rate_z", want.fields.rate_z, seen.rate_z);
					check_field("vibration_level", want.fields.vibration_level,
						seen.vibration_level);
					check_field("tilt_angle", want.fields.tilt_angle, seen.tilt_angle);
					check_field("node_state_alert", want.fields.node_state_alert,
						seen.node_state_alert);
				end
			end

			if (s_tvalid && s_tready) begin
				if (byte_cnt == 8'd0) start_hit = (s_tdata == marker);
				if (byte_cnt < CRC_SPAN) crc_acc = ccitt_update(crc_acc, s_tdata);
				if (byte_cnt >= 8'd1 && byte_cnt <= 8'(STORE_DEPTH))
					payload[byte_cnt - 8'd1] = s_tdata;
				if (byte_cnt == CHECK_HI_IDX) rx_check[15:8] = s_tdata;
				if (byte_cnt == CHECK_LO_IDX) rx_check[7:0] = s_tdata;
				if (byte_cnt != COUNT_MAX) byte_cnt++;

				if (s_tlast) begin
					if (byte_cnt != FRAME_LEN)
						want.status = ST_BAD_LEN;
					else if (!start_hit)
						want.status = ST_BAD_START;
					else if (crc_acc != rx_check)
						want.status = ST_BAD_CRC;
					else
						want.status = ST_OK;
					want.fields = '0;
					if (want.status == ST_OK) begin
						want.fields.node_number      = payload[0];
						want.fields.sequence_number  = payload[1];
						want.fields.accel_x          = be_word(2);
						want.fields.accel_y          = be_word(4);
						want.fields.accel_z          = be_word(6);
						want.fields.rate_x           = be_word(8);
						want.fields.rate_y           = be_word(10);
						want.fields.rate_z           = be_word(12);
						want.fields.vibration_level  = be_word(14);
						want.fields.tilt_angle       = be_word(16);
						want.fields.node_state_alert = be_word(18);
					end
					verdict_q.push_back(want);
					byte_cnt = '0;
					crc_acc = CRC_INIT;
					start_hit = 1'b1;
					rx_check = '0;
				end
			end

			// marker write lands after any byte 0 seen at the same edge
			if (cfg_we) marker = cfg_wdata;
		end
		pending <= verdict_q.size();
		failures <= fail_cnt;
	end

endmodule

// ===== bench/tb_sensor_frame_checker.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_checker;

	import sfc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 110;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;     // [7:0] data_byte
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;          // node_number at [7:0] up to node_state_alert at [159:144]
	logic [1:0]   m_tuser;          // [1:0] frame_status
	logic         cfg_we = 1'b0;
	logic [7:0]   cfg_wdata = '0;

	int unsigned pending_frames;
	int unsigned failures;
	int unsigned quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [7:0]  marker_now = MARKER_RESET;
	logic [7:0]  pkt[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sensor_frame_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sfc_frame_monitor mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (pending_frames),
		.failures  (failures)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] field_byte(input int fill, input int pos);
		case (fill)
			0: return 8'h00;
			1: return 8'hFF;
			2: return pos[0] ? 8'h80 : 8'h00;   // most negative words
			3: return pos[0] ? 8'h7F : 8'hFF;   // most positive words
			default: begin
				case ($urandom_range(5))
					0: return 8'h00;
					1: return 8'hFF;
					2: return 8'h80;
					3: return 8'h7F;
					default: return 8'($urandom);
				endcase
			end
		endcase
	endfunction

	// builds a well-formed frame with a good check word over bytes 0..20
	task automatic make_frame(input logic [7:0] first, input int fill);
		logic [15:0] r;
		logic        fb;
		pkt.delete();
		pkt.push_back(first);
		for (int i = 1; i <= STORE_DEPTH; i++) pkt.push_back(field_byte(fill, i));
		r = CRC_INIT;
		foreach (pkt[i]) begin
			for (int k = 7; k >= 0; k--) begin
				fb = r[15] ^ pkt[i][k];
				r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
		end
		pkt.push_back(r[15:8]);
		pkt.push_back(r[7:0]);
	endtask

	task automatic push_word(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_range(input int lo, input int hi);
		for (int i = lo; i < hi; i++) push_word(pkt[i], i == pkt.size() - 1);
	endtask

	// hold the input until every pending result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_frames != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_marker(input logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		marker_now = v;
	endtask

	task automatic random_packet();
		int roll;
		int len;
		roll = $urandom_range(99);
		if (roll < 66) begin
			make_frame(marker_now, 4);
		end else if (roll < 76) begin
			make_frame(marker_now, 4);
			len = $urandom_range(22, 1);
			pkt[len] = pkt[len] ^ (8'h01 << $urandom_range(7));
		end else if (roll < 84) begin
			make_frame(marker_now ^ 8'($urandom_range(255, 1)), 4);
		end else if (roll < 92) begin
			make_frame(marker_now, 4);
			if ($urandom_range(1))
				void'(pkt.pop_back());
			else
				repeat ($urandom_range(3, 1)) pkt.push_back(8'($urandom));
		end else begin
			len = ($urandom_range(15) == 0) ? $urandom_range(300, 250) : $urandom_range(40, 1);
			pkt.delete();
			repeat (len) pkt.push_back(8'($urandom));
			if ($urandom_range(1)) pkt[0] = marker_now;
		end
	endtask

	initial begin
		int idle_send [4];
		int idle_recv [4];
		logic [7:0] phase_marker [4];
		int sent;

		idle_send = '{0, 57, 0, 7};
		idle_recv = '{0, 0, 57, 7};
		phase_marker = '{8'h00, 8'hFF, 8'($urandom), MARKER_RESET};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset marker
		for (int f = 0; f < 4; f++) begin
			make_frame(MARKER_RESET, f);
			send_range(0, pkt.size());
		end
		make_frame(8'h55, 4);                    // bad start byte
		send_range(0, pkt.size());
		make_frame(MARKER_RESET, 4);             // check word low byte off
		pkt[22] = pkt[22] ^ 8'h01;
		send_range(0, pkt.size());
		make_frame(MARKER_RESET, 4);             // check word high byte off
		pkt[21] = pkt[21] ^ 8'h80;
		send_range(0, pkt.size());
		pkt.delete();                            // single-word packet
		pkt.push_back(MARKER_RESET);
		send_range(0, pkt.size());
		make_frame(MARKER_RESET, 4);             // one short
		void'(pkt.pop_back());
		send_range(0, pkt.size());
		make_frame(MARKER_RESET, 4);             // one long
		pkt.push_back(8'h00);
		send_range(0, pkt.size());
		make_frame(8'h00, 4);                    // short and bad start: length wins
		void'(pkt.pop_back());
		send_range(0, pkt.size());
		pkt.delete();                            // count saturates past 255
		pkt.push_back(MARKER_RESET);
		repeat (299) pkt.push_back(8'($urandom));
		send_range(0, pkt.size());

		// marker rewritten mid-frame: byte 0 was judged against the old value
		make_frame(MARKER_RESET, 4);
		send_range(0, 5);
		set_marker(8'h3C);
		send_range(5, pkt.size());
		make_frame(MARKER_RESET, 4);
		send_range(0, pkt.size());

		for (int p = 0; p < 4; p++) begin
			set_marker(phase_marker[p]);
			send_idle_pct = idle_send[p];
			recv_stall_pct = idle_recv[p];
			sent = 0;
			while (sent < PHASE_WORDS) begin
				random_packet();
				send_range(0, pkt.size());
				sent += pkt.size();
			end
		end

		drain();
		if (failures == 0 && pending_frames == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
